// ===== hdl/vrp_pkg.sv =====
// shared types, constants and functions of the vertex rotate and project block
`default_nettype none

package vrp_pkg;

  localparam int AngleEntries = 361;
  localparam int QuarterTurn  = 90;
  localparam int FullTurn     = 360;
  localparam longint DegToRadQ30 = 64'sd18740330;

  localparam int QuoW  = 17;
  localparam int DenW  = 43;
  localparam int BehW  = 72;

  typedef enum logic [2:0] {
    CfgRotation = 3'd0,
    CfgTilt     = 3'd1,
    CfgDistance = 3'd2,
    CfgXOrigin  = 3'd3,
    CfgYOrigin  = 3'd4,
    CfgXField   = 3'd5,
    CfgYField   = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] screen_depth;
    logic               behind_eye;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic                   behind;
    logic                   last;
    logic                   ovf_x;
    logic                   ovf_y;
    logic                   neg_x;
    logic                   neg_y;
    logic signed [15:0]     depth;
    logic signed [BehW-1:0] bx;
    logic signed [BehW-1:0] by;
  } side_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [DenW-1:0] rem_x;
    logic [DenW-1:0] rem_y;
    logic [QuoW-1:0] lo_x;
    logic [QuoW-1:0] lo_y;
    side_t           side;
  } cell_t;

  typedef logic [0:90][15:0] quarter_t;

  // quotient of two non-negative values, for table building only
  function automatic longint div_pos(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((n >>> i) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  function automatic quarter_t build_quarter();
    quarter_t tab;
    longint   x;
    longint   term;
    longint   sum;
    longint   q;
    for (int d = 0; d <= QuarterTurn; d++) begin
      x = longint'(d) * DegToRadQ30;
      term = x;
      sum = x;
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >>> 30;
        term = (term * x) >>> 30;
        term = div_pos(term, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      q = (sum + 64'sd16384) >>> 15;
      if (q > 32767) q = 32767;
      tab[d] = q[15:0];
    end
    return tab;
  endfunction

  localparam quarter_t QuarterSine = build_quarter();

  function automatic logic signed [15:0] sine_at(input logic [8:0] d);
    logic signed [15:0] r;
    if (d <= 9'd90) r = QuarterSine[d[6:0]];
    else if (d <= 9'd180) r = QuarterSine[7'(9'd180 - d)];
    else if (d <= 9'd270) r = -$signed(QuarterSine[7'(d - 9'd180)]);
    else r = -$signed(QuarterSine[7'(9'd360 - d)]);
    return r;
  endfunction

  function automatic logic [8:0] wrap_angle(input logic [8:0] a);
    return (a >= 9'(AngleEntries)) ? a - 9'(FullTurn) : a;
  endfunction

  function automatic logic [8:0] cos_index(input logic [8:0] w);
    logic [9:0] s;
    s = {1'b0, w} + 10'(QuarterTurn);
    return (s >= 10'(FullTurn)) ? 9'(s - 10'(FullTurn)) : 9'(s);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [79:0] v);
    logic signed [15:0] r;
    if (v > 80'sd32767) r = 16'sh7fff;
    else if (v < -80'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vrp_div_cell.sv =====
// one restoring divide step for the x and y quotients, registered
`default_nettype none

module vrp_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  vrp_pkg::cell_t      word_i,
  output logic                valid_o,
  output vrp_pkg::cell_t      word_o
);

  logic [vrp_pkg::DenW:0]   rx2, ry2, dext, dfx, dfy;
  logic                     gex, gey;
  vrp_pkg::cell_t           word_d, word_q;
  logic                     valid_q;

  assign dext = {1'b0, word_i.den};
  assign rx2  = {word_i.rem_x, word_i.lo_x[vrp_pkg::QuoW-1]};
  assign ry2  = {word_i.rem_y, word_i.lo_y[vrp_pkg::QuoW-1]};
  assign gex  = rx2 >= dext;
  assign gey  = ry2 >= dext;
  assign dfx  = rx2 - dext;
  assign dfy  = ry2 - dext;

  always_comb begin
    word_d       = word_i;
    word_d.rem_x = gex ? dfx[vrp_pkg::DenW-1:0] : rx2[vrp_pkg::DenW-1:0];
    word_d.rem_y = gey ? dfy[vrp_pkg::DenW-1:0] : ry2[vrp_pkg::DenW-1:0];
    word_d.lo_x  = {word_i.lo_x[vrp_pkg::QuoW-2:0], gex};
    word_d.lo_y  = {word_i.lo_y[vrp_pkg::QuoW-2:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ===== hdl/vrp_div_chain.sv =====
// row of divide cells, one quotient bit per cell
`default_nettype none

module vrp_div_chain (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  vrp_pkg::cell_t      word_i,
  output logic                valid_o,
  output vrp_pkg::cell_t      word_o
);

  logic           valid_s [0:vrp_pkg::QuoW];
  vrp_pkg::cell_t word_s  [0:vrp_pkg::QuoW];

  assign valid_s[0] = valid_i;
  assign word_s[0]  = word_i;

  for (genvar i = 0; i < vrp_pkg::QuoW; i++) begin : g_cell
    vrp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_s[i]),
      .word_i  (word_s[i]),
      .valid_o (valid_s[i+1]),
      .word_o  (word_s[i+1])
    );
  end

  assign valid_o = valid_s[vrp_pkg::QuoW];
  assign word_o  = word_s[vrp_pkg::QuoW];

endmodule

`default_nettype wire

// ===== hdl/vertex_rotate_project.sv =====
// vertex rotate and perspective project, top level
// path: input register, rotation, tilt and distance, numerator registers, divider chain, output register
// throughput: one word per cycle; the whole pipe advances when the output register is free
// the 17-cell divider chain (one quotient bit per cell) sets most of the latency
// reset: config registers to their defaults and all valid bits cleared, no clearing pass
`default_nettype none

module vertex_rotate_project (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  vrp_pkg::in_word_t      in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vrp_pkg::out_word_t     out_word_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i
);

  // config registers
  logic [8:0]         rot_q, tilt_q;
  logic signed [23:0] dist_q;
  logic [9:0]         xo_q, yo_q, xf_q, yf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q  <= 9'd0;
      tilt_q <= 9'd0;
      dist_q <= 24'sd25600;
      xo_q   <= 10'd160;
      yo_q   <= 10'd100;
      xf_q   <= 10'd200;
      yf_q   <= 10'd200;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vrp_pkg::CfgRotation: rot_q  <= cfg_data_i[8:0];
        vrp_pkg::CfgTilt:     tilt_q <= cfg_data_i[8:0];
        vrp_pkg::CfgDistance: dist_q <= cfg_data_i;
        vrp_pkg::CfgXOrigin:  xo_q   <= cfg_data_i[9:0];
        vrp_pkg::CfgYOrigin:  yo_q   <= cfg_data_i[9:0];
        vrp_pkg::CfgXField:   xf_q   <= cfg_data_i[9:0];
        vrp_pkg::CfgYField:   yf_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sines follow the angle registers
  logic [8:0]         ra, ta;
  logic signed [15:0] s1_q, c1_q, s2_q, c2_q;

  assign ra = vrp_pkg::wrap_angle(rot_q);
  assign ta = vrp_pkg::wrap_angle(tilt_q);

  always_ff @(posedge clk_i) begin
    s1_q <= vrp_pkg::sine_at(ra);
    c1_q <= vrp_pkg::sine_at(vrp_pkg::cos_index(ra));
    s2_q <= vrp_pkg::sine_at(ta);
    c2_q <= vrp_pkg::sine_at(vrp_pkg::cos_index(ta));
  end

  logic en;
  logic out_valid_q;
  vrp_pkg::out_word_t out_word_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: input register
  logic               v1_q, last1_q;
  logic signed [23:0] x1_q, y1_q, z1_q;

  // stage 2: first rotation
  logic signed [39:0] p_xc1, p_zs1, p_xs1, p_zc1, p_yc2, p_ys2;
  logic signed [41:0] xe2_d, t2_d;
  logic               v2_q, last2_q;
  logic signed [41:0] xe2_q, t2_q;
  logic signed [39:0] yc2_q, ys2_q;

  assign p_xc1 = x1_q * c1_q;
  assign p_zs1 = z1_q * s1_q;
  assign p_xs1 = x1_q * s1_q;
  assign p_zc1 = z1_q * c1_q;
  assign p_yc2 = y1_q * c2_q;
  assign p_ys2 = y1_q * s2_q;
  assign xe2_d = p_xc1 + p_zs1;
  assign t2_d  = p_zc1 - p_xs1;

  // stage 3: tilt and view distance
  logic signed [42:0] t2x, nt;
  logic signed [57:0] p_tc2;
  logic signed [58:0] p_nts2, zsum, ysum;
  logic signed [43:0] ze3_d, ye3_d;
  logic               v3_q, last3_q;
  logic signed [41:0] xe3_q;
  logic signed [43:0] ye3_q, ze3_q;

  assign t2x    = t2_q;
  assign nt     = -t2x;
  assign p_tc2  = t2_q * c2_q;
  assign p_nts2 = nt * s2_q;
  assign zsum   = p_tc2 + (59'(ys2_q) <<< 15);
  assign ysum   = p_nts2 + (59'(yc2_q) <<< 15);
  assign ze3_d  = 44'(zsum >>> 15) + (44'(dist_q) <<< 15);
  assign ye3_d  = 44'(ysum >>> 15);

  // stage 4: numerators and behind-eye products
  logic               behind4_d;
  logic signed [55:0] nx, ny;
  logic signed [44:0] zb, nzb;
  logic [29:0]        nz8;
  logic signed [26:0] xe8;
  logic signed [28:0] ye8;
  logic signed [57:0] px;
  logic signed [59:0] py;
  logic signed [23:0] sd_raw;
  logic               v4_q, last4_q, behind4_q;
  logic signed [55:0] nx4_q, ny4_q;
  logic signed [43:0] ze4_q;
  logic signed [57:0] px4_q;
  logic signed [59:0] py4_q;
  logic signed [15:0] sd4_q;

  assign behind4_d = !(ze3_q > 44'sd0);
  assign nx  = $signed({1'b0, xo_q}) * ze3_q + $signed({1'b0, xf_q}) * xe3_q;
  assign ny  = $signed({1'b0, yo_q}) * ze3_q - $signed({1'b0, yf_q}) * ye3_q;
  assign zb  = ze3_q - 45'sd8388608;
  assign nzb = -zb;
  assign nz8 = nzb[44:15];
  assign xe8 = xe3_q[41:15];
  assign ye8 = ye3_q[43:15];
  assign px  = xe8 * $signed({1'b0, nz8});
  assign py  = ye8 * $signed({1'b0, nz8});
  assign sd_raw = behind4_d ? -$signed({2'b00, nzb[44:23]})
                            : $signed({3'b000, ze3_q[43:23]});

  // divider entry
  logic [55:0]        ax, ay;
  logic [42:0]        den;
  logic signed [71:0] bx, by;
  vrp_pkg::cell_t     cell_in;

  assign ax  = nx4_q[55] ? -nx4_q : nx4_q;
  assign ay  = ny4_q[55] ? -ny4_q : ny4_q;
  assign den = ze4_q[42:0];
  assign bx  = $signed({1'b0, xf_q}) * px4_q;
  assign by  = $signed({1'b0, yf_q}) * py4_q;

  always_comb begin
    cell_in             = '0;
    cell_in.den         = den;
    cell_in.rem_x       = {4'b0000, ax[55:17]};
    cell_in.rem_y       = {4'b0000, ay[55:17]};
    cell_in.lo_x        = ax[16:0];
    cell_in.lo_y        = ay[16:0];
    cell_in.side.behind = behind4_q;
    cell_in.side.last   = last4_q;
    cell_in.side.ovf_x  = {4'b0000, ax[55:17]} >= den;
    cell_in.side.ovf_y  = {4'b0000, ay[55:17]} >= den;
    cell_in.side.neg_x  = nx4_q[55];
    cell_in.side.neg_y  = ny4_q[55];
    cell_in.side.depth  = sd4_q;
    cell_in.side.bx     = bx;
    cell_in.side.by     = by;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q      <= in_word_i.world_x;
      y1_q      <= in_word_i.world_y;
      z1_q      <= in_word_i.world_z;
      last1_q   <= in_word_i.last_vertex;
      xe2_q     <= xe2_d;
      t2_q      <= t2_d;
      yc2_q     <= p_yc2;
      ys2_q     <= p_ys2;
      last2_q   <= last1_q;
      xe3_q     <= xe2_q;
      ye3_q     <= ye3_d;
      ze3_q     <= ze3_d;
      last3_q   <= last2_q;
      behind4_q <= behind4_d;
      nx4_q     <= nx;
      ny4_q     <= ny;
      ze4_q     <= ze3_q;
      px4_q     <= px;
      py4_q     <= py;
      sd4_q     <= vrp_pkg::sat16(80'(sd_raw));
      last4_q   <= last3_q;
    end
  end

  logic           chain_valid;
  vrp_pkg::cell_t co;

  vrp_div_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .word_i  (cell_in),
    .valid_o (chain_valid),
    .word_o  (co)
  );

  // result assembly
  logic [17:0]        mag_x, mag_y;
  logic signed [18:0] vx, vy;
  logic signed [73:0] tx, ty, trx, try_v;
  vrp_pkg::out_word_t out_word_d;

  assign mag_x = co.side.ovf_x ? 18'h20000 : {1'b0, co.lo_x};
  assign mag_y = co.side.ovf_y ? 18'h20000 : {1'b0, co.lo_y};
  assign vx    = co.side.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
  assign vy    = co.side.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
  assign tx    = co.side.bx + $signed({1'b0, xo_q, 16'h0000});
  assign ty    = $signed({1'b0, yo_q, 16'h0000}) - co.side.by;
  assign trx   = tx + (tx[73] ? 74'sd65535 : 74'sd0);
  assign try_v = ty + (ty[73] ? 74'sd65535 : 74'sd0);

  always_comb begin
    out_word_d.screen_x     = co.side.behind ? vrp_pkg::sat16(80'(trx >>> 16))
                                             : vrp_pkg::sat16(80'(vx));
    out_word_d.screen_y     = co.side.behind ? vrp_pkg::sat16(80'(try_v >>> 16))
                                             : vrp_pkg::sat16(80'(vy));
    out_word_d.screen_depth = co.side.depth;
    out_word_d.behind_eye   = co.side.behind;
    out_word_d.last_out     = co.side.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_behind_depth_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.behind_eye |-> out_word_o.screen_depth[15])
    else $error("behind-eye word with non-negative depth");

  a_front_depth_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.behind_eye |-> !out_word_o.screen_depth[15])
    else $error("front word with negative depth");

endmodule

`default_nettype wire
